// File: design/psc_pkg.sv
// psc_pkg: shared widths and the control bundle for the palindromic substring counter
// used by psc_cell and palindromic_substring_counter; no dependencies
package psc_pkg;

  localparam int SYM_W = 8;   // one string byte
  localparam int EH_W  = 9;   // palindromes ending at a byte, as reported
  localparam int TOT_W = 32;  // running total, saturating

  // control broadcast to every cell in the row
  typedef struct packed {
    logic shift;  // a byte was taken: compare, then shift the row
    logic clr;    // end of string: forget history
  } cell_ctl_t;

endpackage

// File: design/psc_cell.sv
// psc_cell: one slot of the history row; holds a byte, its valid bit and a hit bit
// depends on psc_pkg (cell_ctl_t, SYM_W)
module psc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  psc_pkg::cell_ctl_t        ctl,
  input  logic [psc_pkg::SYM_W-1:0] sym,      // new byte from the input
  input  logic [psc_pkg::SYM_W-1:0] rc_in,    // byte from the left neighbor
  input  logic                      vld_in,   // valid from the left neighbor
  input  logic                      ep_in,    // shorter palindrome ended at previous byte
  output logic [psc_pkg::SYM_W-1:0] rc_out,
  output logic                      vld_out,
  output logic                      hit_out
);
  import psc_pkg::*;

  logic [SYM_W-1:0] rc_r;
  logic             vld_r, vld_nxt;
  logic             hit_r, hit_nxt;
  logic             now_w;

  // palindrome of this cell's length ends at the new byte
  assign now_w = vld_r && ep_in && (sym == rc_r);

  always_comb begin
    vld_nxt = vld_r;
    hit_nxt = hit_r;
    if (ctl.clr) begin
      vld_nxt = 1'b0;
      hit_nxt = 1'b0;
    end else if (ctl.shift) begin
      vld_nxt = vld_in;
      hit_nxt = now_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
    end
  end

  // byte itself needs no reset, the valid bit guards it
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rc_r <= rc_in;
    end
  end

  assign rc_out  = rc_r;
  assign vld_out = vld_r;
  assign hit_out = hit_r;

endmodule

// File: design/psc_popcnt.sv
// psc_popcnt: registered binary adder tree counting the set hit bits of the row
// no package dependencies; every level of the tree is registered, inputs held until the root settles
module psc_popcnt #(
  parameter int N = 255
) (
  input  logic                   clk,
  input  logic [N-1:0]           bits,
  output logic [$clog2(N+1)-1:0] count
);
  localparam int W = $clog2(N + 1);
  localparam int P = 2 ** $clog2(N);

  logic [W-1:0] leaf [P];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign leaf[i] = W'(bits[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  if (P > 1) begin : g_tree
    logic [W-1:0] node_r [P-1];
    logic [W-1:0] a_w    [P-1];
    logic [W-1:0] b_w    [P-1];

    for (genvar i = 0; i < P - 1; i++) begin : g_node
      localparam int C0 = 2 * i + 1;
      if (C0 >= P - 1) begin : g_from_leaf
        assign a_w[i] = leaf[C0-(P-1)];
        assign b_w[i] = leaf[C0-(P-1)+1];
      end else begin : g_from_node
        assign a_w[i] = node_r[C0];
        assign b_w[i] = node_r[C0+1];
      end
      always_ff @(posedge clk) begin
        node_r[i] <= a_w[i] + b_w[i];
      end
    end
    assign count = node_r[0];
  end else begin : g_single
    assign count = leaf[0];
  end

endmodule

// File: design/palindromic_substring_counter.sv
// palindromic_substring_counter: top level, row of compare cells plus count and total
// depends on psc_pkg, psc_cell, psc_popcnt
//
// usage
//   input channel  : in_valid / in_ready with in_symbol (one byte) and in_last
//                    (marks the final byte of a string); one request per byte
//   result channel : out_valid / out_ready, one result per input byte:
//                    out_ending_here   palindromes ending at this byte (low 9 bits)
//                    out_running_total palindromes so far in the string, saturating
//                    out_string_done   this byte closed the string
//                    out_too_long      string ran past MAX_LEN bytes
//   timing         : a byte is compared against the whole history row in the
//                    cycle it is taken; the hit bits then go through a registered
//                    adder tree of clog2(MAX_LEN-1) levels; out_valid rises when
//                    the count is loaded into the output register, and the next
//                    byte can be taken in that same cycle, not before
//   stall          : the result sits in an output register; the next byte is taken
//                    while it waits, but that byte's result holds in the tree
//                    until the register frees up
//   reset          : rst_n (synchronous, active low) empties the history, the
//                    position count and the total; the same happens after each
//                    byte marked last, once its result is loaded
module palindromic_substring_counter #(
  parameter int MAX_LEN = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [psc_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [psc_pkg::EH_W-1:0]  out_ending_here,
  output logic [psc_pkg::TOT_W-1:0] out_running_total,
  output logic                      out_string_done,
  output logic                      out_too_long
);
  import psc_pkg::*;

  // one cell per palindrome length 2..MAX_LEN; length 1 always counts
  localparam int NC   = MAX_LEN - 1;
  localparam int HW   = $clog2(NC + 1);      // hit count width
  localparam int CW   = $clog2(MAX_LEN + 1); // per-byte count width
  localparam int PW   = $clog2(MAX_LEN + 1); // position width
  localparam int LV   = $clog2(NC);          // adder tree levels
  localparam int WTW  = $clog2(LV + 2);      // wait counter width

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [WTW-1:0]   wait_r, wait_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [EH_W-1:0]  out_eh_r;
  logic [TOT_W-1:0] out_tot_r;
  logic             out_done_r;
  logic             out_ovf_r;

  logic             accept;
  logic             fin;
  cell_ctl_t        ctl;

  // history row
  logic [SYM_W-1:0] rc_w  [NC];
  logic             vld_w [NC];
  logic [NC-1:0]    hit_w;

  logic [HW-1:0]    hits_cnt;
  logic [CW-1:0]    count_w;
  logic [TOT_W:0]   sum_w;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // count has settled at the tree root and the output register can take it
  assign fin      = (state_r == ST_BUSY) && (wait_r == '0) && (!out_valid_r || out_ready);

  assign ctl.shift = accept;
  assign ctl.clr   = fin && last_r;

  // cell j compares the new byte with the byte j+1 places back; it needs the
  // palindrome two lengths shorter, which cell j-2 found on the previous byte
  for (genvar j = 0; j < NC; j++) begin : g_row
    logic [SYM_W-1:0] rc_in_w;
    logic             vld_in_w;
    logic             ep_w;

    if (j == 0) begin : g_head
      assign rc_in_w  = in_symbol;
      assign vld_in_w = 1'b1;
    end else begin : g_body
      assign rc_in_w  = rc_w[j-1];
      assign vld_in_w = vld_w[j-1];
    end

    // empty and single-byte palindromes always end at the previous byte
    if (j < 2) begin : g_ep_const
      assign ep_w = 1'b1;
    end else begin : g_ep_chain
      assign ep_w = hit_w[j-2];
    end

    psc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sym     (in_symbol),
      .rc_in   (rc_in_w),
      .vld_in  (vld_in_w),
      .ep_in   (ep_w),
      .rc_out  (rc_w[j]),
      .vld_out (vld_w[j]),
      .hit_out (hit_w[j])
    );
  end

  psc_popcnt #(
    .N (NC)
  ) u_popcnt (
    .clk   (clk),
    .bits  (hit_w),
    .count (hits_cnt)
  );

  // plus one for the single-byte palindrome
  assign count_w = CW'(hits_cnt) + CW'(1);
  assign sum_w   = {1'b0, total_r} + (TOT_W + 1)'(count_w);

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
          wait_nxt  = WTW'(LV);
          last_nxt  = in_last;
          // position saturates; one byte past the limit marks the string long
          if (pos_r == PW'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      ST_BUSY: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - WTW'(1);
        end else if (fin) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (last_r) begin
            pos_nxt   = '0;
            ovf_nxt   = 1'b0;
            total_nxt = '0;
          end else begin
            total_nxt = sum_w[TOT_W] ? '1 : sum_w[TOT_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded when the count is handed over
  always_ff @(posedge clk) begin
    if (fin) begin
      out_eh_r   <= EH_W'(count_w);
      out_tot_r  <= sum_w[TOT_W] ? '1 : sum_w[TOT_W-1:0];
      out_done_r <= last_r;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ending_here   = out_eh_r;
  assign out_running_total = out_tot_r;
  assign out_string_done   = out_done_r;
  assign out_too_long      = out_ovf_r;

  // taking a byte always starts the count
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_BUSY)
    else $error("byte taken without entering busy");

  // end of string empties position and total
  a_clear_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    fin && last_r |=> pos_r == '0 && total_r == '0 && !ovf_r)
    else $error("string state not cleared after last byte");

  // total never falls inside a string
  a_total_mono : assert property (@(posedge clk) disable iff (!rst_n)
    fin && !last_r |=> total_r >= $past(total_r))
    else $error("running total decreased");

  // an empty string has no valid history
  a_empty_history : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == '0 |-> !vld_w[0])
    else $error("history valid at start of string");

  // a result is only loaded while the output register is free or draining
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !fin)
    else $error("result overwritten while stalled");

endmodule
